// ===== rtl/mqd_pkg.sv =====
// mqd_pkg: shared types, constants and the Qe probability table of the MQ decoder
// used by mqd_coder and mq_arithmetic_decoder; depends on nothing else
package mqd_pkg;

   // fixed field and register widths
   localparam int CFG_W = 13;
   localparam int POS_W = 13;
   localparam int IDX_W = 6;

   // decoder constants
   localparam logic [IDX_W-1:0] QE_LAST      = 6'd46;
   localparam logic [15:0]      A_INIT       = 16'h8000;
   localparam logic [31:0]      C_ADD_BYTE   = 32'h0000_FF00;
   localparam logic [31:0]      C_ADD_STUFF  = 32'h0000_FE00;
   localparam logic [7:0]       BYTE_FF      = 8'hFF;
   localparam logic [7:0]       MARKER_LIMIT = 8'h8F;

   // request function codes
   typedef enum logic [1:0] {
      FUNC_LOAD    = 2'd0,
      FUNC_SET_CTX = 2'd1,
      FUNC_START   = 2'd2,
      FUNC_DECODE  = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [4:0]  ctx;
      logic [5:0]  init_index;
      logic        init_mps;
      logic [11:0] byte_addr;
      logic [7:0]  byte_value;
   } req_type;

   typedef struct packed {
      logic decision;
      logic decision_valid;
   } rsp_type;

   // one context memory entry
   typedef struct packed {
      logic             mps;
      logic [IDX_W-1:0] index;
   } ctx_entry_type;

   // one probability table entry
   typedef struct packed {
      logic [15:0]      qe;
      logic [IDX_W-1:0] nmps;
      logic [IDX_W-1:0] nlps;
      logic             sw;
   } qe_entry_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_RENORM,
      S_FETCH_RD,
      S_FETCH,
      S_START_TAKE,
      S_START_FIN,
      S_PUSH
   } state_type;

   // operations of the coder datapath
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_DECIDE,
      OP_SHIFT,
      OP_FETCH,
      OP_START_TAKE,
      OP_START_FIN
   } coder_op_type;

   typedef struct packed {
      coder_op_type  op;
      logic [7:0]    byte_data;
      logic          byte_avail;
      ctx_entry_type ctx;
   } coder_ctl_type;

   typedef struct packed {
      logic             a_msb;
      logic             need_byte;
      logic [POS_W-1:0] read_pos;
      logic             decision;
      logic             ctx_write;
      ctx_entry_type    ctx_next;
      logic             renorm;
   } coder_stat_type;

   // standard Qe / NMPS / NLPS / SWITCH table
   function automatic qe_entry_type qe_lookup(input logic [IDX_W-1:0] index);
      qe_entry_type e;
      case (index)
         6'd0:    e = '{16'h5601, 6'd1,  6'd1,  1'b1};
         6'd1:    e = '{16'h3401, 6'd2,  6'd6,  1'b0};
         6'd2:    e = '{16'h1801, 6'd3,  6'd9,  1'b0};
         6'd3:    e = '{16'h0AC1, 6'd4,  6'd12, 1'b0};
         6'd4:    e = '{16'h0521, 6'd5,  6'd29, 1'b0};
         6'd5:    e = '{16'h0221, 6'd38, 6'd33, 1'b0};
         6'd6:    e = '{16'h5601, 6'd7,  6'd6,  1'b1};
         6'd7:    e = '{16'h5401, 6'd8,  6'd14, 1'b0};
         6'd8:    e = '{16'h4801, 6'd9,  6'd14, 1'b0};
         6'd9:    e = '{16'h3801, 6'd10, 6'd14, 1'b0};
         6'd10:   e = '{16'h3001, 6'd11, 6'd17, 1'b0};
         6'd11:   e = '{16'h2401, 6'd12, 6'd18, 1'b0};
         6'd12:   e = '{16'h1C01, 6'd13, 6'd20, 1'b0};
         6'd13:   e = '{16'h1601, 6'd29, 6'd21, 1'b0};
         6'd14:   e = '{16'h5601, 6'd15, 6'd14, 1'b1};
         6'd15:   e = '{16'h5401, 6'd16, 6'd14, 1'b0};
         6'd16:   e = '{16'h5101, 6'd17, 6'd15, 1'b0};
         6'd17:   e = '{16'h4801, 6'd18, 6'd16, 1'b0};
         6'd18:   e = '{16'h3801, 6'd19, 6'd17, 1'b0};
         6'd19:   e = '{16'h3401, 6'd20, 6'd18, 1'b0};
         6'd20:   e = '{16'h3001, 6'd21, 6'd19, 1'b0};
         6'd21:   e = '{16'h2801, 6'd22, 6'd19, 1'b0};
         6'd22:   e = '{16'h2401, 6'd23, 6'd20, 1'b0};
         6'd23:   e = '{16'h2201, 6'd24, 6'd21, 1'b0};
         6'd24:   e = '{16'h1C01, 6'd25, 6'd22, 1'b0};
         6'd25:   e = '{16'h1801, 6'd26, 6'd23, 1'b0};
         6'd26:   e = '{16'h1601, 6'd27, 6'd24, 1'b0};
         6'd27:   e = '{16'h1401, 6'd28, 6'd25, 1'b0};
         6'd28:   e = '{16'h1201, 6'd29, 6'd26, 1'b0};
         6'd29:   e = '{16'h1101, 6'd30, 6'd27, 1'b0};
         6'd30:   e = '{16'h0AC1, 6'd31, 6'd28, 1'b0};
         6'd31:   e = '{16'h09C1, 6'd32, 6'd29, 1'b0};
         6'd32:   e = '{16'h08A1, 6'd33, 6'd30, 1'b0};
         6'd33:   e = '{16'h0521, 6'd34, 6'd31, 1'b0};
         6'd34:   e = '{16'h0441, 6'd35, 6'd32, 1'b0};
         6'd35:   e = '{16'h02A1, 6'd36, 6'd33, 1'b0};
         6'd36:   e = '{16'h0221, 6'd37, 6'd34, 1'b0};
         6'd37:   e = '{16'h0141, 6'd38, 6'd35, 1'b0};
         6'd38:   e = '{16'h0111, 6'd39, 6'd36, 1'b0};
         6'd39:   e = '{16'h0085, 6'd40, 6'd37, 1'b0};
         6'd40:   e = '{16'h0049, 6'd41, 6'd38, 1'b0};
         6'd41:   e = '{16'h0025, 6'd42, 6'd39, 1'b0};
         6'd42:   e = '{16'h0015, 6'd43, 6'd40, 1'b0};
         6'd43:   e = '{16'h0009, 6'd44, 6'd41, 1'b0};
         6'd44:   e = '{16'h0005, 6'd45, 6'd42, 1'b0};
         6'd45:   e = '{16'h0001, 6'd45, 6'd43, 1'b0};
         default: e = '{16'h5601, 6'd46, 6'd46, 1'b0};
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/mqd_ram.sv =====
// mqd_ram: generic single-clock RAM, one write port and one registered read port
// depends on nothing else
module mqd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mqd_coder.sv =====
// mqd_coder: interval and code registers of the MQ decoder with the decision,
// renormalization shift and byte-in steps; depends on mqd_pkg
module mqd_coder (
   input  logic                    clock,
   input  logic                    reset,
   input  mqd_pkg::coder_ctl_type  ctl,
   output mqd_pkg::coder_stat_type stat
);
   import mqd_pkg::*;

   logic [15:0]      a_ff, a_in;
   logic [31:0]      c_ff, c_in;
   logic [3:0]       bc_ff, bc_in;
   logic [7:0]       last_ff, last_in;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic [IDX_W-1:0] idx_clamped;
   qe_entry_type     qe;
   logic [15:0]      a_sub;
   logic             high_lt;
   logic             a_small;
   logic             take_lps;
   logic             fast_mps;
   logic [4:0]       lz;
   logic [3:0]       shift_k;
   logic [7:0]       in_byte;
   logic             marker;

   // leading zeros of the interval register
   function automatic logic [4:0] lead_zeros(input logic [15:0] value);
      logic [4:0] n;
      n = 5'd16;
      for (int i = 0; i < 16; i++) begin
         if (value[i]) begin
            n = 5'(15 - i);
         end
      end
      return n;
   endfunction

   // decision from the context entry and the table
   always_comb begin
      idx_clamped = (ctl.ctx.index > QE_LAST) ? QE_LAST : ctl.ctx.index;
      qe          = qe_lookup(idx_clamped);
      a_sub       = a_ff - qe.qe;
      high_lt     = c_ff[31:16] < a_sub;
      a_small     = a_sub < qe.qe;
      fast_mps    = high_lt && a_sub[15];
      take_lps    = high_lt ? a_small : !a_small;
   end

   // shift amount: up to the next byte boundary or until the interval is normal
   always_comb begin
      lz      = lead_zeros(a_ff);
      shift_k = ({1'b0, bc_ff} < lz) ? bc_ff : lz[3:0];
   end

   // byte-in data: reads past the end give 0xff
   always_comb begin
      in_byte = ctl.byte_avail ? ctl.byte_data : BYTE_FF;
      marker  = (last_ff == BYTE_FF) && (in_byte > MARKER_LIMIT);
   end

   // register next values
   always_comb begin
      a_in    = a_ff;
      c_in    = c_ff;
      bc_in   = bc_ff;
      last_in = last_ff;
      pos_in  = pos_ff;
      case (ctl.op)
         OP_DECIDE: begin
            if (high_lt) begin
               a_in = a_sub;
            end else begin
               c_in = {c_ff[31:16] - a_sub, c_ff[15:0]};
               a_in = qe.qe;
            end
         end
         OP_SHIFT: begin
            a_in  = a_ff << shift_k;
            c_in  = c_ff << shift_k;
            bc_in = bc_ff - shift_k;
         end
         OP_FETCH: begin
            if (last_ff == BYTE_FF) begin
               if (marker) begin
                  bc_in = 4'd8;
               end else begin
                  last_in = in_byte;
                  pos_in  = pos_ff + POS_W'(ctl.byte_avail);
                  c_in    = c_ff + C_ADD_STUFF - 32'({in_byte, 9'd0});
                  bc_in   = 4'd7;
               end
            end else begin
               last_in = in_byte;
               pos_in  = pos_ff + POS_W'(ctl.byte_avail);
               c_in    = c_ff + C_ADD_BYTE - 32'({in_byte, 8'd0});
               bc_in   = 4'd8;
            end
         end
         OP_START_TAKE: begin
            last_in = in_byte;
            c_in    = {8'd0, in_byte ^ BYTE_FF, 16'd0};
            pos_in  = POS_W'(ctl.byte_avail);
         end
         OP_START_FIN: begin
            c_in  = c_ff << 7;
            bc_in = bc_ff - 4'd7;
            a_in  = A_INIT;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff    <= A_INIT;
         c_ff    <= '0;
         bc_ff   <= '0;
         last_ff <= '0;
         pos_ff  <= '0;
      end else begin
         a_ff    <= a_in;
         c_ff    <= c_in;
         bc_ff   <= bc_in;
         last_ff <= last_in;
         pos_ff  <= pos_in;
      end
   end

   // status toward the sequencer
   always_comb begin
      stat.a_msb          = a_ff[15];
      stat.need_byte      = (bc_ff == 4'd0);
      stat.read_pos       = pos_ff;
      stat.decision       = take_lps ? ~ctl.ctx.mps : ctl.ctx.mps;
      stat.ctx_write      = !fast_mps;
      stat.ctx_next.mps   = (take_lps && qe.sw) ? ~ctl.ctx.mps : ctl.ctx.mps;
      stat.ctx_next.index = take_lps ? qe.nlps : qe.nmps;
      stat.renorm         = !fast_mps;
   end

   // byte-in always leaves seven or eight bits to shift
   assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_FETCH |=> (bc_ff == 4'd7 || bc_ff == 4'd8))
      else $error("bit count after byte-in is not seven or eight");

   // a shift step only runs on a denormal interval with bits left
   assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_SHIFT |-> (!a_ff[15] && bc_ff != 4'd0))
      else $error("shift step issued with nothing to shift");

   // the interval never collapses to zero during renormalization
   assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_SHIFT |=> a_ff != 16'd0)
      else $error("interval register became zero");

endmodule

// ===== rtl/mq_arithmetic_decoder.sv =====
// mq_arithmetic_decoder: MQ binary arithmetic decoder top level, sequencer,
// context memory and code byte store; depends on mqd_pkg, mqd_ram, mqd_coder
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_data (func, ctx, init_index, ...)
//   rsp      out        rsp_valid/rsp_ready    rsp_data (decision, decision_valid)
//   csr      in         csr_wr_en              csr_wr_data (stream_length)
//
// load byte and set context finish from the idle state; start reads the first
// byte, fetches the next one and then shifts the code register. decode reads the
// context and decides; off the fast MPS path it renormalizes, with shift steps and
// code byte fetches. each context read and each byte fetch waits on the
// registered memory read port. after reset the context memory is cleared entry
// by entry before the first request is taken; csr writes are taken throughout.
// a finished result waits in an output register while the next request runs.
module mq_arithmetic_decoder #(
   parameter int NUM_CONTEXTS = 32,
   parameter int STORE_BYTES  = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  mqd_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mqd_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [mqd_pkg::CFG_W-1:0]   csr_wr_data
);
   import mqd_pkg::*;

   localparam int CTX_W   = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
   localparam int ADDR_W  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int ENTRY_W = $bits(ctx_entry_type);
   localparam logic [31:0]      STORE_LIMIT = 32'(STORE_BYTES);
   localparam logic [CTX_W-1:0] CLEAR_LAST  = CTX_W'(NUM_CONTEXTS - 1);

   // sequencer and handshake registers
   state_type          state_ff, state_in;
   logic [CTX_W-1:0]   clr_ff, clr_in;
   logic               start_mode_ff, start_mode_in;
   logic               avail_ff, avail_in;
   logic [CTX_W-1:0]   ctx_sel_ff, ctx_sel_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [CFG_W-1:0]   stream_len_ff, stream_len_in;

   // memory ports
   logic               ctx_wr_en;
   logic [CTX_W-1:0]   ctx_wr_addr;
   ctx_entry_type      ctx_wr_data;
   logic               ctx_rd_en;
   logic [ENTRY_W-1:0] ctx_rd_data;
   logic               byte_wr_en;
   logic               byte_rd_en;
   logic [ADDR_W-1:0]  byte_rd_addr;
   logic [7:0]         byte_rd_data;

   // coder link
   coder_ctl_type      ctl;
   coder_stat_type     stat;
   coder_op_type       ctl_op;

   logic               fin_req;
   logic               fin_valid;
   rsp_type            fin_rsp;
   rsp_type            decided_rsp;
   logic               out_free;
   state_type          fin_next;
   logic [CTX_W-1:0]   ctx_wrap;
   logic [ADDR_W-1:0]  addr_wrap;
   logic [IDX_W-1:0]   set_index;
   logic               byte_avail_now;

   // remainder of a small value by a constant, quotient below 256
   function automatic logic [11:0] wrap_mod(input logic [11:0] value,
                                            input int unsigned modulus);
      logic [11:0] rem;
      logic [31:0] part;
      rem = value;
      for (int s = 7; s >= 0; s--) begin
         part = 32'(modulus) << s;
         if ({20'd0, rem} >= part) begin
            rem = rem - part[11:0];
         end
      end
      return rem;
   endfunction

   // request decode helpers
   always_comb begin
      ctx_wrap  = CTX_W'(wrap_mod({7'd0, req_data.ctx}, NUM_CONTEXTS));
      addr_wrap = ADDR_W'(wrap_mod(req_data.byte_addr, STORE_BYTES));
      set_index = (req_data.init_index > QE_LAST) ? QE_LAST : req_data.init_index;
   end

   // byte store read address and end-of-stream check
   always_comb begin
      if (state_ff == S_IDLE) begin
         byte_rd_addr   = '0;
         byte_avail_now = (stream_len_ff != '0);
      end else begin
         byte_rd_addr   = ADDR_W'(stat.read_pos);
         byte_avail_now = (stat.read_pos < stream_len_ff)
                          && (32'(stat.read_pos) < STORE_LIMIT);
      end
   end

   // output slot
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      fin_valid   = fin_req && out_free;
      fin_next    = out_free ? S_IDLE : S_PUSH;
      decided_rsp = '{decision: stat.decision, decision_valid: 1'b1};
      case (state_ff)
         S_IDLE:   fin_rsp = '0;
         S_DECIDE: fin_rsp = decided_rsp;
         default:  fin_rsp = res_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.func)
                  FUNC_LOAD:    state_in = fin_next;
                  FUNC_SET_CTX: state_in = fin_next;
                  FUNC_START:   state_in = S_START_TAKE;
                  default:      state_in = S_DECIDE;
               endcase
            end
         end
         S_DECIDE: begin
            state_in = stat.renorm ? S_RENORM : fin_next;
         end
         S_RENORM: begin
            if (stat.a_msb) begin
               state_in = fin_next;
            end else if (stat.need_byte) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH_RD:   state_in = S_FETCH;
         S_FETCH:      state_in = start_mode_ff ? S_START_FIN : S_RENORM;
         S_START_TAKE: state_in = S_FETCH_RD;
         S_START_FIN:  state_in = fin_next;
         S_PUSH:       state_in = fin_next;
         default:      state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      fin_req     = 1'b0;
      ctx_wr_en   = 1'b0;
      ctx_wr_addr = ctx_sel_ff;
      ctx_wr_data = stat.ctx_next;
      ctx_rd_en   = 1'b0;
      byte_wr_en  = 1'b0;
      byte_rd_en  = 1'b0;
      ctl_op      = OP_IDLE;
      case (state_ff)
         S_CLEAR: begin
            ctx_wr_en   = 1'b1;
            ctx_wr_addr = clr_ff;
            ctx_wr_data = '0;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.func)
                  FUNC_LOAD: begin
                     byte_wr_en = 1'b1;
                     fin_req    = 1'b1;
                  end
                  FUNC_SET_CTX: begin
                     ctx_wr_en   = 1'b1;
                     ctx_wr_addr = ctx_wrap;
                     ctx_wr_data = '{mps: req_data.init_mps, index: set_index};
                     fin_req     = 1'b1;
                  end
                  FUNC_START: begin
                     byte_rd_en = 1'b1;
                  end
                  default: begin
                     ctx_rd_en = 1'b1;
                  end
               endcase
            end
         end
         S_DECIDE: begin
            ctl_op    = OP_DECIDE;
            ctx_wr_en = stat.ctx_write;
            fin_req   = !stat.renorm;
         end
         S_RENORM: begin
            if (stat.a_msb) begin
               fin_req = 1'b1;
            end else if (stat.need_byte) begin
               byte_rd_en = 1'b1;
            end else begin
               ctl_op = OP_SHIFT;
            end
         end
         S_FETCH_RD: begin
            byte_rd_en = 1'b1;
         end
         S_FETCH: begin
            ctl_op = OP_FETCH;
         end
         S_START_TAKE: begin
            ctl_op = OP_START_TAKE;
         end
         S_START_FIN: begin
            ctl_op  = OP_START_FIN;
            fin_req = 1'b1;
         end
         S_PUSH: begin
            fin_req = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      clr_in        = (state_ff == S_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      start_mode_in = start_mode_ff;
      ctx_sel_in    = ctx_sel_ff;
      res_in        = res_ff;
      if (state_ff == S_IDLE && req_valid) begin
         start_mode_in = (req_data.func == FUNC_START);
         ctx_sel_in    = ctx_wrap;
         res_in        = '0;
      end
      if (state_ff == S_DECIDE) begin
         res_in = decided_rsp;
      end
      avail_in      = byte_rd_en ? byte_avail_now : avail_ff;
      rsp_valid_in  = fin_valid || (rsp_valid_ff && !rsp_ready);
      rsp_data_in   = fin_valid ? fin_rsp : rsp_data_ff;
      stream_len_in = csr_wr_en ? csr_wr_data : stream_len_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         start_mode_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         stream_len_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         start_mode_ff <= start_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
         stream_len_ff <= stream_len_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      avail_ff    <= avail_in;
      ctx_sel_ff  <= ctx_sel_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // context memory: mps and probability index per context
   mqd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_CONTEXTS)
   ) u_ctx_ram (
      .clock   (clock),
      .wr_en   (ctx_wr_en),
      .wr_addr (ctx_wr_addr),
      .wr_data (ctx_wr_data),
      .rd_en   (ctx_rd_en),
      .rd_addr (ctx_wrap),
      .rd_data (ctx_rd_data)
   );

   // code byte store
   mqd_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_wr_en),
      .wr_addr (addr_wrap),
      .wr_data (req_data.byte_value),
      .rd_en   (byte_rd_en),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd_data)
   );

   // coder datapath
   always_comb begin
      ctl.op         = ctl_op;
      ctl.byte_data  = byte_rd_data;
      ctl.byte_avail = avail_ff;
      ctl.ctx        = ctx_entry_type'(ctx_rd_data);
   end

   mqd_coder u_coder (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .stat  (stat)
   );

   // the decision step always works on a freshly read context entry
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DECIDE |-> $past(ctx_rd_en))
      else $error("decision step without a context read");

   // byte-in always follows a byte store read
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |-> $past(byte_rd_en))
      else $error("byte-in without a byte store read");

   // a decision that needs renormalization leaves a denormal interval
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && stat.renorm) |=> !stat.a_msb)
      else $error("renormalization entered with a normal interval");

endmodule

// ===== tb/sv/mq_decision_sb_pkg.sv =====
// mq_decision_sb_pkg: scoreboard class for the MQ decoder testbench, with its own
// copy of the decoder state, the Qe table and the queue of expected responses
// depends on mqd_pkg for the request and response types
package mq_decision_sb_pkg;
   import mqd_pkg::*;

   localparam int         STORE_SIZE = 4096;
   localparam int         CTX_COUNT  = 32;
   localparam logic [5:0] LAST_STATE = 6'd46;

   class decision_scoreboard;
      // probability state table: Qe, next on MPS, next on LPS, switch
      qe_entry_type prob_rows[47];

      // decoder state mirrored from the block
      logic [12:0] stream_len;
      logic        ctx_mps_q[CTX_COUNT];
      logic [5:0]  ctx_idx_q[CTX_COUNT];
      logic [15:0] a_reg;
      logic [31:0] c_reg;
      logic [3:0]  ct;
      logic [7:0]  prev_byte;
      logic [12:0] rd_pos;
      logic [7:0]  code_bytes[STORE_SIZE];

      rsp_type expected_rsps[$];
      int      errors;
      int      rsp_count;

      function new();
         prob_rows = '{
            '{16'h5601, 6'd1,  6'd1,  1'b1}, '{16'h3401, 6'd2,  6'd6,  1'b0},
            '{16'h1801, 6'd3,  6'd9,  1'b0}, '{16'h0AC1, 6'd4,  6'd12, 1'b0},
            '{16'h0521, 6'd5,  6'd29, 1'b0}, '{16'h0221, 6'd38, 6'd33, 1'b0},
            '{16'h5601, 6'd7,  6'd6,  1'b1}, '{16'h5401, 6'd8,  6'd14, 1'b0},
            '{16'h4801, 6'd9,  6'd14, 1'b0}, '{16'h3801, 6'd10, 6'd14, 1'b0},
            '{16'h3001, 6'd11, 6'd17, 1'b0}, '{16'h2401, 6'd12, 6'd18, 1'b0},
            '{16'h1C01, 6'd13, 6'd20, 1'b0}, '{16'h1601, 6'd29, 6'd21, 1'b0},
            '{16'h5601, 6'd15, 6'd14, 1'b1}, '{16'h5401, 6'd16, 6'd14, 1'b0},
            '{16'h5101, 6'd17, 6'd15, 1'b0}, '{16'h4801, 6'd18, 6'd16, 1'b0},
            '{16'h3801, 6'd19, 6'd17, 1'b0}, '{16'h3401, 6'd20, 6'd18, 1'b0},
            '{16'h3001, 6'd21, 6'd19, 1'b0}, '{16'h2801, 6'd22, 6'd19, 1'b0},
            '{16'h2401, 6'd23, 6'd20, 1'b0}, '{16'h2201, 6'd24, 6'd21, 1'b0},
            '{16'h1C01, 6'd25, 6'd22, 1'b0}, '{16'h1801, 6'd26, 6'd23, 1'b0},
            '{16'h1601, 6'd27, 6'd24, 1'b0}, '{16'h1401, 6'd28, 6'd25, 1'b0},
            '{16'h1201, 6'd29, 6'd26, 1'b0}, '{16'h1101, 6'd30, 6'd27, 1'b0},
            '{16'h0AC1, 6'd31, 6'd28, 1'b0}, '{16'h09C1, 6'd32, 6'd29, 1'b0},
            '{16'h08A1, 6'd33, 6'd30, 1'b0}, '{16'h0521, 6'd34, 6'd31, 1'b0},
            '{16'h0441, 6'd35, 6'd32, 1'b0}, '{16'h02A1, 6'd36, 6'd33, 1'b0},
            '{16'h0221, 6'd37, 6'd34, 1'b0}, '{16'h0141, 6'd38, 6'd35, 1'b0},
            '{16'h0111, 6'd39, 6'd36, 1'b0}, '{16'h0085, 6'd40, 6'd37, 1'b0},
            '{16'h0049, 6'd41, 6'd38, 1'b0}, '{16'h0025, 6'd42, 6'd39, 1'b0},
            '{16'h0015, 6'd43, 6'd40, 1'b0}, '{16'h0009, 6'd44, 6'd41, 1'b0},
            '{16'h0005, 6'd45, 6'd42, 1'b0}, '{16'h0001, 6'd45, 6'd43, 1'b0},
            '{16'h5601, 6'd46, 6'd46, 1'b0}
         };
         stream_len = '0;
         foreach (ctx_mps_q[i]) ctx_mps_q[i] = 1'b0;
         foreach (ctx_idx_q[i]) ctx_idx_q[i] = '0;
         foreach (code_bytes[i]) code_bytes[i] = '0;
         a_reg     = 16'h8000;
         c_reg     = '0;
         ct        = '0;
         prev_byte = '0;
         rd_pos    = '0;
         errors    = 0;
         rsp_count = 0;
      endfunction

      function void set_length(input logic [12:0] len);
         stream_len = len;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      // past the stream length every byte reads as 0xFF
      function bit byte_ready();
         return (rd_pos < stream_len) && (int'(rd_pos) < STORE_SIZE);
      endfunction

      function logic [7:0] peek_byte();
         return byte_ready() ? code_bytes[rd_pos[11:0]] : 8'hFF;
      endfunction

      function logic [7:0] take_byte();
         logic [7:0] v;
         if (!byte_ready())
            return 8'hFF;
         v = code_bytes[rd_pos[11:0]];
         rd_pos = rd_pos + 13'd1;
         return v;
      endfunction

      // byte-in with stuffing after 0xFF and marker detection
      function void fetch_byte();
         if (prev_byte == 8'hFF) begin
            if (peek_byte() > 8'h8F) begin
               ct = 4'd8;
            end else begin
               prev_byte = take_byte();
               c_reg = c_reg + (32'h0000_FE00 - ({24'd0, prev_byte} << 9));
               ct = 4'd7;
            end
         end else begin
            prev_byte = take_byte();
            c_reg = c_reg + (32'h0000_FF00 - ({24'd0, prev_byte} << 8));
            ct = 4'd8;
         end
      endfunction

      function void renormalize();
         do begin
            if (ct == 4'd0)
               fetch_byte();
            a_reg = a_reg << 1;
            c_reg = c_reg << 1;
            ct = ct - 4'd1;
         end while (!a_reg[15]);
      endfunction

      // one decision with MPS/LPS exchange and context update
      function logic decode_decision(input logic [4:0] cx);
         qe_entry_type row;
         logic         mps;
         logic         d;
         row = prob_rows[ctx_idx_q[cx]];
         mps = ctx_mps_q[cx];
         a_reg = a_reg - row.qe;
         if (c_reg[31:16] < a_reg) begin
            if (a_reg[15])
               return mps;
            if (a_reg < row.qe) begin
               d = ~mps;
               if (row.sw) ctx_mps_q[cx] = ~mps;
               ctx_idx_q[cx] = row.nlps;
            end else begin
               d = mps;
               ctx_idx_q[cx] = row.nmps;
            end
         end else begin
            c_reg = c_reg - {a_reg, 16'h0000};
            if (a_reg < row.qe) begin
               d = mps;
               ctx_idx_q[cx] = row.nmps;
            end else begin
               d = ~mps;
               if (row.sw) ctx_mps_q[cx] = ~mps;
               ctx_idx_q[cx] = row.nlps;
            end
            a_reg = row.qe;
         end
         renormalize();
         return d;
      endfunction

      // initialization from the head of the stream
      function void start_stream();
         rd_pos = '0;
         prev_byte = take_byte();
         c_reg = {24'd0, prev_byte ^ 8'hFF} << 16;
         fetch_byte();
         c_reg = c_reg << 7;
         ct = ct - 4'd7;
         a_reg = 16'h8000;
      endfunction

      // accepted request: update the state and queue the response it causes
      function void note_request(input req_type r);
         rsp_type e;
         e = '0;
         case (r.func)
            FUNC_LOAD: begin
               code_bytes[r.byte_addr] = r.byte_value;
            end
            FUNC_SET_CTX: begin
               ctx_idx_q[r.ctx] = (r.init_index > LAST_STATE) ? LAST_STATE : r.init_index;
               ctx_mps_q[r.ctx] = r.init_mps;
            end
            FUNC_START: begin
               start_stream();
            end
            default: begin
               e.decision       = decode_decision(r.ctx);
               e.decision_valid = 1'b1;
            end
         endcase
         expected_rsps.push_back(e);
      endfunction

      task report(input string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      // accepted response against the oldest expectation
      task check_response(input rsp_type got);
         rsp_type want;
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            report($sformatf("response %0d arrived with no request outstanding", rsp_count));
            return;
         end
         want = expected_rsps.pop_front();
         if (got.decision_valid !== want.decision_valid)
            report($sformatf("response %0d: decision_valid got %b want %b",
                             rsp_count, got.decision_valid, want.decision_valid));
         if (got.decision !== want.decision)
            report($sformatf("response %0d: decision got %b want %b",
                             rsp_count, got.decision, want.decision));
      endtask
   endclass

endpackage

// ===== tb/sv/testbench.sv =====
// testbench: drives mq_arithmetic_decoder with byte loads, context setup, starts
// and decodes under random idling, and checks every response against the scoreboard
// depends on mqd_pkg, mq_decision_sb_pkg and the decoder RTL
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mqd_pkg::*;
   import mq_decision_sb_pkg::*;

   localparam int CYCLE_LIMIT   = 800000;
   localparam int SETTLE_CYCLES = 8;
   localparam int FILL_MAX      = 186;
   localparam int DECODES_MAX   = 60;
   localparam int PHASE_ITEMS   = 80;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]  csr_wr_data = '0;

   decision_scoreboard sb;
   bit                 quiet = 1'b0;
   int                 cycle_count = 0;

   mq_arithmetic_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side stalls about a third of the cycles unless quiet is set
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 33);
   end

   // observe register writes, accepted requests and accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            sb.set_length(csr_wr_data);
         if (req_valid && req_ready)
            sb.note_request(req_data);
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_data);
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   function automatic req_type random_req(input func_type f);
      req_type r;
      r.func       = f;
      r.ctx        = 5'($urandom);
      r.init_index = 6'($urandom);
      r.init_mps   = 1'($urandom);
      r.byte_addr  = 12'($urandom);
      r.byte_value = 8'($urandom);
      return r;
   endfunction

   // hold the request until accepted, then maybe idle
   task automatic send_request(input req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      while (!quiet && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_load(input logic [11:0] addr, input logic [7:0] value);
      req_type r;
      r = random_req(FUNC_LOAD);
      r.byte_addr  = addr;
      r.byte_value = value;
      send_request(r);
   endtask

   task automatic send_set(input logic [4:0] cx, input logic [5:0] idx, input logic mps);
      req_type r;
      r = random_req(FUNC_SET_CTX);
      r.ctx        = cx;
      r.init_index = idx;
      r.init_mps   = mps;
      send_request(r);
   endtask

   task automatic send_start();
      send_request(random_req(FUNC_START));
   endtask

   task automatic send_decode(input logic [4:0] cx);
      req_type r;
      r = random_req(FUNC_DECODE);
      r.ctx = cx;
      send_request(r);
   endtask

   // stop sending and wait until every response is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_stream_length(input int len);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CFG_W'(len);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // one stream length: fill the stream head, start, then mostly decodes.
   // at most three bytes per decode plus two at start are read, so the
   // filled head always covers what the decoder can reach
   task automatic run_phase(input int len, input bit no_idle);
      int         fill;
      int         since_start;
      int         pick;
      logic [7:0] b;
      logic [7:0] prev;
      wait_for_drain();
      write_stream_length(len);
      quiet = no_idle;
      fill = (len < FILL_MAX) ? len : FILL_MAX;
      prev = 8'h00;
      for (int i = 0; i < fill; i++) begin
         // after 0xFF either a marker or a stuffed byte, else mostly random
         if (prev == 8'hFF)
            b = $urandom_range(1) ? 8'($urandom_range(255, 144)) : 8'($urandom_range(143, 0));
         else
            b = ($urandom_range(99) < 12) ? 8'hFF : 8'($urandom_range(255));
         send_load(12'(i), b);
         prev = b;
      end
      send_start();
      since_start = 0;
      repeat (PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (since_start >= DECODES_MAX || pick < 4) begin
            send_start();
            since_start = 0;
         end else if (pick < 16) begin
            send_set(5'($urandom), 6'($urandom), 1'($urandom));
         end else if (pick < 22) begin
            send_load(12'($urandom), 8'($urandom));
         end else begin
            send_decode((pick < 60) ? 5'($urandom_range(3)) : 5'($urandom));
            since_start++;
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      int phase_len[10];
      sb = new();
      phase_len = '{1, 2, 3, 6, 4096, 12, 4095, 40, 0, 0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // decode before any start, on reset registers and an empty stream
      send_decode(5'd0);
      send_decode(5'd31);
      // index above the table end is clamped
      send_set(5'd31, 6'd63, 1'b1);
      send_set(5'd0, 6'd0, 1'b0);
      // start with nothing in the stream reads all ones
      send_start();
      send_decode(5'd31);
      send_decode(5'd0);

      // short stream with stuffing, a marker and reads past the end
      wait_for_drain();
      write_stream_length(10);
      send_load(12'd0, 8'h00);
      send_load(12'd1, 8'hFF);
      send_load(12'd2, 8'h7F);
      send_load(12'd3, 8'h3C);
      send_load(12'd4, 8'hFF);
      send_load(12'd5, 8'h8F);
      send_load(12'd6, 8'hA5);
      send_load(12'd7, 8'hFF);
      send_load(12'd8, 8'h90);
      send_load(12'd9, 8'h12);
      send_load(12'd4095, 8'hFF);
      // smallest Qe forces the longest renormalization
      send_set(5'd5, 6'd45, 1'b1);
      send_set(5'd6, 6'd46, 1'b0);
      send_start();
      send_decode(5'd5);
      send_decode(5'd5);
      send_decode(5'd6);
      send_decode(5'd31);

      // random part over several stream lengths, one phase without idling
      for (int p = 0; p < 10; p++)
         run_phase((p == 9) ? int'($urandom_range(4096, 100)) : phase_len[p], p == 4);

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== mq_arithmetic_decoder.f =====
rtl/mqd_pkg.sv
rtl/mqd_ram.sv
rtl/mqd_coder.sv
rtl/mq_arithmetic_decoder.sv
tb/sv/mq_decision_sb_pkg.sv
tb/sv/testbench.sv
